// ----- rtl/tag_pkg.sv -----
// ----------------------------------------------------------------------------
// tag_pkg
// Shared types, constants and the arctangent table of the tilt-to-gear block.
// ----------------------------------------------------------------------------
package tag_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STAGES   = 25;
  localparam int DIV_STAGES    = 18;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int PADDR_W       = 5;

  // cordic datapath widths
  localparam int CW = 29;
  localparam int ZW = 28;

  localparam logic signed [ZW-1:0] ANGLE_RIGHT    = 28'sd58982400;
  localparam logic signed [ZW-1:0] ANGLE_STRAIGHT = 28'sd117964800;

  localparam logic [2:0] REG_X_OFFSET  = 3'd0;
  localparam logic [2:0] REG_Y_OFFSET  = 3'd1;
  localparam logic [2:0] REG_Z_OFFSET  = 3'd2;
  localparam logic [2:0] REG_ANGLE_LO  = 3'd3;
  localparam logic [2:0] REG_ANGLE_HI  = 3'd4;
  localparam logic [2:0] REG_GEAR_LO   = 3'd5;
  localparam logic [2:0] REG_GEAR_HI   = 3'd6;

  typedef struct packed {
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic signed [15:0] z_offset;
    logic signed [11:0] angle_low_limit;
    logic signed [11:0] angle_high_limit;
    logic [4:0]         gear_min;
    logic [4:0]         gear_max;
  } cfg_t;

  typedef struct packed {
    logic [32:0] sq;
    logic [15:0] ady;
    logic        pos;
    logic        neg;
  } q_item_t;

  // atan(2^-i) in units of 2^-16 tenth degree
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 28'sd29491200;
      1:  v = 28'sd17409672;
      2:  v = 28'sd9198793;
      3:  v = 28'sd4669451;
      4:  v = 28'sd2343786;
      5:  v = 28'sd1173036;
      6:  v = 28'sd586661;
      7:  v = 28'sd293348;
      8:  v = 28'sd146676;
      9:  v = 28'sd73339;
      10: v = 28'sd36669;
      11: v = 28'sd18335;
      12: v = 28'sd9167;
      13: v = 28'sd4584;
      14: v = 28'sd2292;
      15: v = 28'sd1146;
      16: v = 28'sd573;
      17: v = 28'sd286;
      18: v = 28'sd143;
      19: v = 28'sd72;
      20: v = 28'sd36;
      21: v = 28'sd18;
      22: v = 28'sd9;
      23: v = 28'sd4;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/tag_if.sv -----
// ----------------------------------------------------------------------------
// tag_if
// Valid/ready channels for accelerometer samples and gear results.
// ----------------------------------------------------------------------------
interface tag_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_raw;
  logic signed [15:0] y_raw;
  logic signed [15:0] z_raw;

  modport source (output valid, x_raw, y_raw, z_raw, input ready);
  modport sink   (input valid, x_raw, y_raw, z_raw, output ready);
endinterface

interface tag_res_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] tilt_angle;
  logic [4:0]         gear_number;

  modport source (output valid, tilt_angle, gear_number, input ready);
  modport sink   (input valid, tilt_angle, gear_number, output ready);
endinterface

// ----- rtl/tag_front.sv -----
// ----------------------------------------------------------------------------
// tag_front
// Takes samples, removes offsets, classifies sign cases and forms dx^2+dz^2.
// ----------------------------------------------------------------------------
module tag_front import tag_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  tag_smp_if.sink smp_i,
  input  cfg_t    cfg_i,
  output logic    push_valid_o,
  input  logic    push_ready_i,
  output q_item_t push_item_o
);

  logic               fv_q;
  logic signed [16:0] dx_q, dy_q, dz_q;
  logic signed [33:0] px, pz;
  logic signed [16:0] ndy;

  assign smp_i.ready = !fv_q || push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (smp_i.ready) begin
      fv_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      dx_q <= $signed({smp_i.x_raw[15], smp_i.x_raw}) -
              $signed({cfg_i.x_offset[15], cfg_i.x_offset});
      dy_q <= $signed({smp_i.y_raw[15], smp_i.y_raw}) -
              $signed({cfg_i.y_offset[15], cfg_i.y_offset});
      dz_q <= $signed({smp_i.z_raw[15], smp_i.z_raw}) -
              $signed({cfg_i.z_offset[15], cfg_i.z_offset});
    end
  end

  assign px  = 34'(dx_q) * 34'(dx_q);
  assign pz  = 34'(dz_q) * 34'(dz_q);
  assign ndy = -dy_q;

  always_comb begin
    push_item_o.sq  = {1'b0, px[31:0]} + {1'b0, pz[31:0]};
    push_item_o.ady = dy_q[16] ? ndy[15:0] : dy_q[15:0];
    // gravity mostly along +z selects the upright half
    push_item_o.pos = dz_q > 17'sd2048;
    push_item_o.neg = dy_q[16];
  end

  assign push_valid_o = fv_q;

endmodule

// ----- rtl/tag_queue.sv -----
// ----------------------------------------------------------------------------
// tag_queue
// Short first-in first-out queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module tag_queue import tag_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  q_item_t push_item_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output q_item_t pop_item_o
);

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/tag_back.sv -----
// ----------------------------------------------------------------------------
// tag_back
// Square root, cordic vectoring, angle fold and gear mapping pipeline.
// ----------------------------------------------------------------------------
module tag_back import tag_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  q_item_t   in_item_i,
  tag_res_if.source res_o
);

  logic en;
  logic out_vld_q;

  // whole pipeline moves together whenever the output register frees up
  assign en         = !out_vld_q || res_o.ready;
  assign in_ready_o = en;

  // ---------------- square root, one result bit per stage
  logic        sv_q    [SQRT_STAGES];
  logic [32:0] ssq_q   [SQRT_STAGES];
  logic [27:0] srem_q  [SQRT_STAGES];
  logic [24:0] sroot_q [SQRT_STAGES];
  logic [15:0] sady_q  [SQRT_STAGES];
  logic        spos_q  [SQRT_STAGES];
  logic        sneg_q  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic        pv, ppos, pneg;
    logic [32:0] psq;
    logic [27:0] prem;
    logic [24:0] proot;
    logic [15:0] pady;
    logic [49:0] v;
    logic [27:0] rem_sh, trial;

    if (k == 0) begin : g_first
      assign pv    = in_valid_i;
      assign psq   = in_item_i.sq;
      assign prem  = '0;
      assign proot = '0;
      assign pady  = in_item_i.ady;
      assign ppos  = in_item_i.pos;
      assign pneg  = in_item_i.neg;
    end else begin : g_next
      assign pv    = sv_q[k-1];
      assign psq   = ssq_q[k-1];
      assign prem  = srem_q[k-1];
      assign proot = sroot_q[k-1];
      assign pady  = sady_q[k-1];
      assign ppos  = spos_q[k-1];
      assign pneg  = sneg_q[k-1];
    end

    assign v      = {1'b0, psq, 16'b0};
    assign rem_sh = {prem[25:0], v[49-2*k -: 2]};
    assign trial  = {1'b0, proot, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en) begin
        sv_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ssq_q[k]  <= psq;
        sady_q[k] <= pady;
        spos_q[k] <= ppos;
        sneg_q[k] <= pneg;
        if (rem_sh >= trial) begin
          srem_q[k]  <= rem_sh - trial;
          sroot_q[k] <= {proot[23:0], 1'b1};
        end else begin
          srem_q[k]  <= rem_sh;
          sroot_q[k] <= {proot[23:0], 1'b0};
        end
      end
    end
  end

  // ---------------- cordic vectoring
  logic                 cv_q   [CORDIC_STAGES];
  logic signed [CW-1:0] cx_q   [CORDIC_STAGES];
  logic signed [CW-1:0] cy_q   [CORDIC_STAGES];
  logic signed [ZW-1:0] cz_q   [CORDIC_STAGES];
  logic                 cxz_q  [CORDIC_STAGES];
  logic                 cyz_q  [CORDIC_STAGES];
  logic                 cpos_q [CORDIC_STAGES];
  logic                 cneg_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic                 pv, pxz, pyz, ppos, pneg;
    logic signed [CW-1:0] px, py, xs, ys;
    logic signed [ZW-1:0] pz;

    if (i == 0) begin : g_first
      assign pv   = sv_q[SQRT_STAGES-1];
      assign px   = $signed({4'b0, sroot_q[SQRT_STAGES-1]});
      assign py   = $signed({5'b0, sady_q[SQRT_STAGES-1], 8'b0});
      assign pz   = '0;
      assign pxz  = sroot_q[SQRT_STAGES-1] == '0;
      assign pyz  = sady_q[SQRT_STAGES-1] == '0;
      assign ppos = spos_q[SQRT_STAGES-1];
      assign pneg = sneg_q[SQRT_STAGES-1];
    end else begin : g_next
      assign pv   = cv_q[i-1];
      assign px   = cx_q[i-1];
      assign py   = cy_q[i-1];
      assign pz   = cz_q[i-1];
      assign pxz  = cxz_q[i-1];
      assign pyz  = cyz_q[i-1];
      assign ppos = cpos_q[i-1];
      assign pneg = cneg_q[i-1];
    end

    assign xs = px >>> i;
    assign ys = py >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i] <= 1'b0;
      end else if (en) begin
        cv_q[i] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cxz_q[i]  <= pxz;
        cyz_q[i]  <= pyz;
        cpos_q[i] <= ppos;
        cneg_q[i] <= pneg;
        if (!py[CW-1]) begin
          cx_q[i] <= px + ys;
          cy_q[i] <= py - xs;
          cz_q[i] <= pz + atan_entry(i);
        end else begin
          cx_q[i] <= px - ys;
          cy_q[i] <= py + xs;
          cz_q[i] <= pz - atan_entry(i);
        end
      end
    end
  end

  // ---------------- angle fold into signed tenths of a degree
  logic                 av_q;
  logic signed [11:0]   ang_q;
  logic signed [ZW-1:0] zl, theta, mag;
  logic [10:0]          ang_u;
  logic signed [11:0]   ang_d;

  assign zl = cz_q[CORDIC_STAGES-1];

  always_comb begin
    if (cyz_q[CORDIC_STAGES-1]) begin
      theta = '0;
    end else if (cxz_q[CORDIC_STAGES-1]) begin
      theta = ANGLE_RIGHT;
    end else if (zl < 0) begin
      theta = '0;
    end else if (zl > ANGLE_RIGHT) begin
      theta = ANGLE_RIGHT;
    end else begin
      theta = zl;
    end
    mag   = cpos_q[CORDIC_STAGES-1] ? theta : ANGLE_STRAIGHT - theta;
    ang_u = mag[26:16];
    ang_d = cneg_q[CORDIC_STAGES-1] ? -$signed({1'b0, ang_u}) : $signed({1'b0, ang_u});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
    end else if (en) begin
      av_q <= cv_q[CORDIC_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q <= ang_d;
    end
  end

  // ---------------- linear map numerator and divisor
  logic               pv_q, pqneg_q, peq_q;
  logic [17:0]        pnum_q;
  logic [11:0]        pden_q;
  logic signed [11:0] pang_q;
  logic signed [12:0] diff, den, nden;
  logic signed [5:0]  dg;
  logic signed [18:0] num, nnum;

  assign diff = $signed({ang_q[11], ang_q}) -
                $signed({cfg_i.angle_low_limit[11], cfg_i.angle_low_limit});
  assign den  = $signed({cfg_i.angle_high_limit[11], cfg_i.angle_high_limit}) -
                $signed({cfg_i.angle_low_limit[11], cfg_i.angle_low_limit});
  assign dg   = $signed({1'b0, cfg_i.gear_max}) - $signed({1'b0, cfg_i.gear_min});
  assign num  = 19'(diff) * 19'(dg);
  assign nnum = -num;
  assign nden = -den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= av_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pnum_q  <= num[18] ? nnum[17:0] : num[17:0];
      pden_q  <= den[12] ? nden[11:0] : den[11:0];
      pqneg_q <= num[18] ^ den[12];
      peq_q   <= cfg_i.angle_high_limit == cfg_i.angle_low_limit;
      pang_q  <= ang_q;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  logic               dv_q   [DIV_STAGES];
  logic [17:0]        dnum_q [DIV_STAGES];
  logic [11:0]        dden_q [DIV_STAGES];
  logic [11:0]        drem_q [DIV_STAGES];
  logic [17:0]        dquo_q [DIV_STAGES];
  logic               dqn_q  [DIV_STAGES];
  logic               deq_q  [DIV_STAGES];
  logic signed [11:0] dang_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic               pv, pqn, peq;
    logic [17:0]        pnum, pquo;
    logic [11:0]        pden, prem;
    logic signed [11:0] pang;
    logic [12:0]        rem_sh, rem_sub;

    if (j == 0) begin : g_first
      assign pv   = pv_q;
      assign pnum = pnum_q;
      assign pden = pden_q;
      assign prem = '0;
      assign pquo = '0;
      assign pqn  = pqneg_q;
      assign peq  = peq_q;
      assign pang = pang_q;
    end else begin : g_next
      assign pv   = dv_q[j-1];
      assign pnum = dnum_q[j-1];
      assign pden = dden_q[j-1];
      assign prem = drem_q[j-1];
      assign pquo = dquo_q[j-1];
      assign pqn  = dqn_q[j-1];
      assign peq  = deq_q[j-1];
      assign pang = dang_q[j-1];
    end

    assign rem_sh  = {prem, pnum[DIV_STAGES-1-j]};
    assign rem_sub = rem_sh - {1'b0, pden};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dnum_q[j] <= pnum;
        dden_q[j] <= pden;
        dqn_q[j]  <= pqn;
        deq_q[j]  <= peq;
        dang_q[j] <= pang;
        if (rem_sh >= {1'b0, pden}) begin
          drem_q[j] <= rem_sub[11:0];
          dquo_q[j] <= {pquo[16:0], 1'b1};
        end else begin
          drem_q[j] <= rem_sh[11:0];
          dquo_q[j] <= {pquo[16:0], 1'b0};
        end
      end
    end
  end

  // ---------------- sign fix, offset, clamp and output register
  logic signed [19:0] qs, gsum, g_lo, g_hi;
  logic signed [19:0] gear;
  logic signed [11:0] tilt_q;
  logic [4:0]         gear_q;

  assign g_lo = $signed({15'b0, cfg_i.gear_min});
  assign g_hi = $signed({15'b0, cfg_i.gear_max});
  assign qs   = dqn_q[DIV_STAGES-1] ? -$signed({2'b0, dquo_q[DIV_STAGES-1]})
                                    : $signed({2'b0, dquo_q[DIV_STAGES-1]});
  assign gsum = qs + g_lo;

  always_comb begin
    gear = deq_q[DIV_STAGES-1] ? g_lo : gsum;
    if (gear < g_lo) begin
      gear = g_lo;
    end
    if (gear > g_hi) begin
      gear = g_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tilt_q <= dang_q[DIV_STAGES-1];
      gear_q <= gear[4:0];
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.tilt_angle  = tilt_q;
  assign res_o.gear_number = gear_q;

endmodule

// ----- rtl/tilt_angle_to_gear.sv -----
// ----------------------------------------------------------------------------
// tilt_angle_to_gear
// Accelerometer tilt angle by square root and cordic, mapped onto a gear.
// Path from sample transaction to result valid, when not stalled: front register
//   at the transaction edge, then queue, 25 root stages, 16 cordic stages,
//   2 map stages, 18 divider stages, output register.
// Throughput: one sample per cycle while res_o.ready holds; the fully pipelined back end sets it.
// Reset: registers take their reset values, pipeline and queue come up empty.
// ----------------------------------------------------------------------------
module tilt_angle_to_gear import tag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  tag_smp_if.sink            smp_i,
  tag_res_if.source          res_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  q_item_t    push_item, pop_item;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_offset         <= '0;
      cfg_q.y_offset         <= '0;
      cfg_q.z_offset         <= '0;
      cfg_q.angle_low_limit  <= -12'sd900;
      cfg_q.angle_high_limit <= 12'sd900;
      cfg_q.gear_min         <= 5'd8;
      cfg_q.gear_max         <= 5'd16;
    end else if (wr) begin
      case (idx)
        REG_X_OFFSET: cfg_q.x_offset         <= pwdata[15:0];
        REG_Y_OFFSET: cfg_q.y_offset         <= pwdata[15:0];
        REG_Z_OFFSET: cfg_q.z_offset         <= pwdata[15:0];
        REG_ANGLE_LO: cfg_q.angle_low_limit  <= pwdata[11:0];
        REG_ANGLE_HI: cfg_q.angle_high_limit <= pwdata[11:0];
        REG_GEAR_LO:  cfg_q.gear_min         <= pwdata[4:0];
        REG_GEAR_HI:  cfg_q.gear_max         <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_OFFSET: prdata = {{16{cfg_q.x_offset[15]}}, cfg_q.x_offset};
      REG_Y_OFFSET: prdata = {{16{cfg_q.y_offset[15]}}, cfg_q.y_offset};
      REG_Z_OFFSET: prdata = {{16{cfg_q.z_offset[15]}}, cfg_q.z_offset};
      REG_ANGLE_LO: prdata = {{20{cfg_q.angle_low_limit[11]}}, cfg_q.angle_low_limit};
      REG_ANGLE_HI: prdata = {{20{cfg_q.angle_high_limit[11]}}, cfg_q.angle_high_limit};
      REG_GEAR_LO:  prdata = {27'b0, cfg_q.gear_min};
      REG_GEAR_HI:  prdata = {27'b0, cfg_q.gear_max};
      default:      prdata = '0;
    endcase
  end

  tag_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_i        (smp_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  tag_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  tag_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (pop_valid),
    .in_ready_o (pop_ready),
    .in_item_i  (pop_item),
    .res_o      (res_o)
  );

`ifndef ASSERT_OFF
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.tilt_angle >= -12'sd1800) && (res_o.tilt_angle <= 12'sd1800))
    else $error("tilt angle out of range");

  a_gear_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (cfg_q.gear_min <= cfg_q.gear_max) |->
      (res_o.gear_number >= cfg_q.gear_min) &&
      (res_o.gear_number <= cfg_q.gear_max))
    else $error("gear outside configured window");

  a_gear_crossed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (cfg_q.gear_min > cfg_q.gear_max) |->
      res_o.gear_number == cfg_q.gear_max)
    else $error("crossed gear limits must give highest gear");
`endif

endmodule
